### rtl/core/tufn_pkg.sv
// ----------------------------------------------------------------------------
// tufn_pkg
// Shared types and constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tufn_pkg;

  // Corner coordinates, signed Q8.16
  localparam int COORD_BITS       = 24;
  // Fraction bits of the unit normal components
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_W           = NORMAL_FRAC_BITS + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } tufn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
  } tufn_out_t;

endpackage

`default_nettype wire

### rtl/core/triangle_unit_face_normal.sv
// Throughput: one transaction per cycle while out_ready is high; the
//   32-stage square root and the 15-stage per-bit divider set the depth.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// triangle_unit_face_normal
// Cross product of two triangle edges, scaled to a Q1.14 unit normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_face_normal (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tufn_pkg::tufn_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tufn_pkg::tufn_out_t      out_data
);

  localparam int CB   = tufn_pkg::COORD_BITS;
  localparam int F    = tufn_pkg::NORMAL_FRAC_BITS;
  localparam int NW   = tufn_pkg::NORM_W;
  // Edge width; edges stay below 2^30 at this coordinate width, so no halving
  localparam int EW   = CB + 1;
  localparam int PW   = 2 * EW;
  localparam int MAGW = 2 * EW;
  localparam int NRMW = (MAGW > 31) ? MAGW : 31;
  localparam int SHS  = $clog2(NRMW);
  localparam int QB   = F + 1;
  localparam int NUMW = 31 + F + 1;
  localparam int SQN  = 32;
  // Stage indexes
  localparam int ST_N   = 2;
  localparam int ST_SQ  = 3 + SHS;
  localparam int ST_SQT = ST_SQ + 2;
  localparam int ST_DI  = ST_SQT + SQN;
  localparam int ST_OUT = ST_DI + 1 + QB;
  localparam int LAT    = ST_OUT + 1;
  localparam int MCN    = 2 + SQN;

  logic en;
  logic [LAT-1:0] vld_r;

  // Whole pipeline advances unless the output holds an untaken result
  assign en        = out_ready | ~vld_r[LAT-1];
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 0: edge vectors U = B - A, V = C - A
  logic signed [EW-1:0] u_r [3];
  logic signed [EW-1:0] v_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= EW'(in_data.b_x) - EW'(in_data.a_x);
      u_r[1] <= EW'(in_data.b_y) - EW'(in_data.a_y);
      u_r[2] <= EW'(in_data.b_z) - EW'(in_data.a_z);
      v_r[0] <= EW'(in_data.c_x) - EW'(in_data.a_x);
      v_r[1] <= EW'(in_data.c_y) - EW'(in_data.a_y);
      v_r[2] <= EW'(in_data.c_z) - EW'(in_data.a_z);
    end
  end

  // Stage 1: six partial products of the cross product
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(u_r[1]) * PW'(v_r[2]);
      p_r[1] <= PW'(u_r[2]) * PW'(v_r[1]);
      p_r[2] <= PW'(u_r[2]) * PW'(v_r[0]);
      p_r[3] <= PW'(u_r[0]) * PW'(v_r[2]);
      p_r[4] <= PW'(u_r[0]) * PW'(v_r[1]);
      p_r[5] <= PW'(u_r[1]) * PW'(v_r[0]);
    end
  end

  // Stage 2: cross product, split into sign and magnitude
  logic signed [PW:0]   n_nxt   [3];
  logic [MAGW-1:0]      nmag_nxt[3];
  logic [NRMW-1:0]      nm_r    [SHS+1][3];
  logic [3:0]           tag_r   [ST_N:LAT-2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i]    = (PW+1)'(p_r[2*i]) - (PW+1)'(p_r[2*i+1]);
      nmag_nxt[i] = n_nxt[i][PW] ? MAGW'(-n_nxt[i]) : MAGW'(n_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm_r[0][i] <= NRMW'(nmag_nxt[i]);
      end
      // tag: {neg x, neg y, neg z, degenerate}
      tag_r[ST_N] <= {n_nxt[0][PW], n_nxt[1][PW], n_nxt[2][PW],
                      ~|{nmag_nxt[0], nmag_nxt[1], nmag_nxt[2]}};
    end
  end

  // Side-band sign and degenerate flags follow the data
  for (genvar k = ST_N + 1; k <= LAT - 2; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // Normalize: left-shift by binary steps until the largest magnitude
  // reaches the top bit
  for (genvar j = 0; j < SHS; j++) begin : g_norm
    localparam int SH = 1 << (SHS - 1 - j);
    logic [NRMW-1:0] or_w;
    assign or_w = nm_r[j][0] | nm_r[j][1] | nm_r[j][2];
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (or_w[NRMW-1 -: SH] == '0) begin
            nm_r[j+1][i] <= nm_r[j][i] << SH;
          end else begin
            nm_r[j+1][i] <= nm_r[j][i];
          end
        end
      end
    end
  end

  // Scaled magnitudes, the largest in [2^30, 2^31) unless all are zero, carried to the divider
  logic [30:0] mc_r [MCN][3];
  logic [61:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mc_r[0][i] <= nm_r[SHS][i][NRMW-1 -: 31];
        sq_r[i]    <= 62'(nm_r[SHS][i][NRMW-1 -: 31]) * 62'(nm_r[SHS][i][NRMW-1 -: 31]);
      end
    end
  end

  for (genvar k = 1; k < MCN; k++) begin : g_mc
    always_ff @(posedge clk) begin
      if (en) begin
        mc_r[k] <= mc_r[k-1];
      end
    end
  end

  // Sum of squares, start of the square root
  logic [63:0] sx_r   [SQN+1];
  logic [63:0] sres_r [SQN+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0]   <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      sres_r[0] <= '0;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sres_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sx_r[k] >= trial) begin
          sx_r[k+1]   <= sx_r[k] - trial;
          sres_r[k+1] <= (sres_r[k] >> 1) + BIT;
        end else begin
          sx_r[k+1]   <= sx_r[k];
          sres_r[k+1] <= sres_r[k] >> 1;
        end
      end
    end
  end

  // Divider setup: numerator = mag * 2^F + L/2, rounds half away from zero
  logic [31:0]     len_nxt;
  logic [31:0]     len_r [QB+1];
  logic [NUMW-1:0] num_r [QB+1][3];
  logic [31:0]     rem_r [QB+1][3];
  logic [QB-1:0]   q_r   [QB+1][3];
  logic [NUMW-1:0] num_nxt [3];

  always_comb begin
    len_nxt = (sres_r[SQN][31:0] == '0) ? 32'd1 : sres_r[SQN][31:0];
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = {mc_r[MCN-1][i], F'(0)} + NUMW'(len_nxt >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= len_nxt;
      for (int i = 0; i < 3; i++) begin
        num_r[0][i] <= num_nxt[i];
        rem_r[0][i] <= 32'(num_nxt[i] >> QB);
        q_r[0][i]   <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage, three lanes
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [32:0] t_w [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t_w[i] = {rem_r[k-1][i], num_r[k-1][i][QB-k]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k] <= len_r[k-1];
        for (int i = 0; i < 3; i++) begin
          num_r[k][i] <= num_r[k-1][i];
          if (t_w[i] >= {1'b0, len_r[k-1]}) begin
            rem_r[k][i] <= 32'(t_w[i] - {1'b0, len_r[k-1]});
            q_r[k][i]   <= {q_r[k-1][i][QB-2:0], 1'b1};
          end else begin
            rem_r[k][i] <= t_w[i][31:0];
            q_r[k][i]   <= {q_r[k-1][i][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register: apply signs, force zeros on a degenerate triangle
  logic [NW-1:0] res_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (tag_r[LAT-2][0]) begin
        res_nxt[i] = '0;
      end else if (tag_r[LAT-2][3-i]) begin
        res_nxt[i] = -NW'(q_r[QB][i]);
      end else begin
        res_nxt[i] = NW'(q_r[QB][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.norm_x     <= res_nxt[0];
      out_data.norm_y     <= res_nxt[1];
      out_data.norm_z     <= res_nxt[2];
      out_data.degenerate <= tag_r[LAT-2][0];
    end
  end

endmodule

`default_nettype wire
